// ===== sv/assert_macros.svh =====
// Assertion macros shared by the raster engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every clock edge while reset is released.
`define FBRE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("raster engine assertion failed");

// Checked on every clock edge, reset included.
`define FBRE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("raster engine assertion failed");

`else

`define FBRE_ASSERT(lbl, clk, rstn, prop)
`define FBRE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== sv/fbre_pkg.sv =====
// Shared types, codes and color conversion for the raster engine.
package fbre_pkg;

    localparam int PIX_W = 24;
    localparam int COV_W = 64;
    localparam int COVER_BIT = 7;

    // Pixel format codes of the color mode register.
    localparam logic [1:0] MODE_555 = 2'd0;
    localparam logic [1:0] MODE_565 = 2'd1;
    localparam logic [1:0] MODE_888 = 2'd2;

    localparam logic [PIX_W-1:0] XOR16_MASK = 24'h00ffff;
    localparam logic [PIX_W-1:0] XOR24_MASK = 24'hffffff;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_XOR   = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ
    } state_t;

    // One pixel operation handed to the write-back stage.
    typedef struct packed {
        logic             valid;
        logic             is_xor;
        logic [PIX_W-1:0] data;
    } step_t;

    // Read command completion toward the output register.
    typedef struct packed {
        logic capture;
        logic hit;
    } rd_res_t;

    // Converts a 24-bit RGB color to the stored pixel format.
    function automatic logic [PIX_W-1:0] convert_color(
        input logic [PIX_W-1:0] rgb,
        input logic [1:0]       mode
    );
        logic [PIX_W-1:0] res;
        case (mode)
            MODE_555: res = {9'd0, rgb[23:19], rgb[15:11], rgb[7:3]};
            MODE_565: res = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
            default:  res = rgb;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/fbre_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module fbre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/fbre_seq.sv =====
// Command sequencer: clearing pass, rectangle and glyph walk, pixel read.
module fbre_seq #(
    parameter int FB_WIDTH = 256,
    parameter int FB_HEIGHT = 256,
    parameter int GLYPH_SPAN = 8,
    parameter int AW = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [7:0]                    s_x,
    input  logic [7:0]                    s_y,
    input  logic [8:0]                    s_width,
    input  logic [8:0]                    s_height,
    input  logic [fbre_pkg::PIX_W-1:0]    s_color,
    input  logic [fbre_pkg::COV_W-1:0]    s_coverage,
    input  logic [1:0]                    color_mode,
    input  logic                          wb_busy,
    input  logic                          out_free,
    output fbre_pkg::step_t               step,
    output logic [AW-1:0]                 mem_addr,
    output logic                          rd_en,
    output fbre_pkg::rd_res_t             rd_res
);
    import fbre_pkg::*;

    localparam int CW  = $clog2(FB_WIDTH);
    localparam int RW  = $clog2(FB_HEIGHT);
    localparam int CXW = $clog2(FB_WIDTH + 512);
    localparam int CYW = $clog2(FB_HEIGHT + 512);
    localparam logic [CXW-1:0] FBW_C = CXW'(FB_WIDTH);
    localparam logic [CYW-1:0] FBH_C = CYW'(FB_HEIGHT);
    localparam logic [8:0]     SPAN_C = 9'(GLYPH_SPAN);

    state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    op_t              op_reg, op_next;
    logic [CXW-1:0]   col_reg, col_next, x_start_reg, x_start_next, x_end_reg, x_end_next;
    logic [CYW-1:0]   row_reg, row_next, y_end_reg, y_end_next;
    logic [PIX_W-1:0] data_reg, data_next;
    logic [COV_W-1:0] cov_reg, cov_next;
    logic             hit_reg, hit_next;

    op_t            in_op;
    logic           accept;
    logic [8:0]     w_eff, h_eff;
    logic [CXW-1:0] x_ext, x_sum;
    logic [CYW-1:0] y_ext, y_sum;
    logic           in_nonempty;
    logic           clr_last, col_last, row_last;
    logic [AW-1:0]  in_addr, walk_addr;

    assign in_op  = op_t'(s_operation);
    assign accept = s_valid && s_ready;
    assign x_ext  = CXW'(s_x);
    assign y_ext  = CYW'(s_y);

    // Extent of the incoming command, clipped to the store.
    always_comb begin
        w_eff = s_width;
        h_eff = s_height;
        if (in_op == OP_GLYPH) begin
            w_eff = (s_width > SPAN_C) ? SPAN_C : s_width;
            h_eff = 9'd1;
        end
        x_sum = x_ext + CXW'(w_eff);
        y_sum = y_ext + CYW'(h_eff);
        x_end_next = (x_sum > FBW_C) ? FBW_C : x_sum;
        y_end_next = (y_sum > FBH_C) ? FBH_C : y_sum;
        in_nonempty = (x_end_next > x_ext) && (y_end_next > y_ext);
    end

    assign clr_last  = &clr_cnt_reg;
    assign col_last  = (col_reg + CXW'(1)) == x_end_reg;
    assign row_last  = (row_reg + CYW'(1)) == y_end_reg;
    assign in_addr   = {y_ext[RW-1:0], x_ext[CW-1:0]};
    assign walk_addr = {row_reg[RW-1:0], col_reg[CW-1:0]};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_READ) begin
                        state_next = ST_READ;
                    end else if (in_nonempty) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (col_last && row_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer toward memory and write-back.
    always_comb begin
        s_ready        = 1'b0;
        step           = '0;
        mem_addr       = walk_addr;
        rd_en          = 1'b0;
        rd_res.capture = 1'b0;
        rd_res.hit     = hit_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                step.valid = 1'b1;
                mem_addr   = clr_cnt_reg;
            end
            ST_IDLE: begin
                s_ready  = !wb_busy;
                mem_addr = in_addr;
                rd_en    = accept && (in_op == OP_READ) && hit_next;
            end
            ST_WALK: begin
                step.valid  = (op_reg != OP_GLYPH) || cov_reg[COVER_BIT];
                step.is_xor = (op_reg == OP_XOR);
                step.data   = data_reg;
                rd_en       = (op_reg == OP_XOR);
            end
            ST_READ: begin
                rd_res.capture = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Walk counters and command fields.
    always_comb begin
        op_next      = op_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        x_start_next = x_start_reg;
        data_next    = data_reg;
        cov_next     = cov_reg;
        hit_next     = (x_ext < FBW_C) && (y_ext < FBH_C);
        if (accept) begin
            op_next      = in_op;
            col_next     = x_ext;
            row_next     = y_ext;
            x_start_next = x_ext;
            data_next    = convert_color(s_color, color_mode);
            cov_next     = s_coverage;
        end else if (state_reg == ST_WALK) begin
            cov_next = cov_reg >> 8;
            if (col_last) begin
                col_next = x_start_reg;
                row_next = row_reg + CYW'(1);
            end else begin
                col_next = col_reg + CXW'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Command registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        x_start_reg <= x_start_next;
        data_reg    <= data_next;
        cov_reg     <= cov_next;
        if (accept) begin
            x_end_reg <= x_end_next;
            y_end_reg <= y_end_next;
            hit_reg   <= hit_next;
        end
    end

endmodule

// ===== sv/fbre_wb.sv =====
// Write-back stage: finishes fills, glyph pixels, xor updates and clearing writes.
module fbre_wb #(
    parameter int AW = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fbre_pkg::step_t            step,
    input  logic [AW-1:0]              step_addr,
    input  logic [1:0]                 color_mode,
    input  logic [fbre_pkg::PIX_W-1:0] rdata,
    output logic                       busy,
    output logic                       we,
    output logic [AW-1:0]              waddr,
    output logic [fbre_pkg::PIX_W-1:0] wdata
);
    import fbre_pkg::*;

    logic             valid_reg;
    logic             is_xor_reg;
    logic [PIX_W-1:0] data_reg;
    logic [AW-1:0]    addr_reg;
    logic [PIX_W-1:0] mask;

    // Stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= step.valid;
        end
    end

    // Stage payload, aligned with the registered memory read.
    always_ff @(posedge aclk) begin
        is_xor_reg <= step.is_xor;
        data_reg   <= step.data;
        addr_reg   <= step_addr;
    end

    // The 555 and 565 formats invert only the low 16 bits.
    always_comb begin
        case (color_mode) inside
            MODE_555, MODE_565: mask = XOR16_MASK;
            default:            mask = XOR24_MASK;
        endcase
    end

    assign busy  = valid_reg;
    assign we    = valid_reg;
    assign waddr = addr_reg;
    assign wdata = is_xor_reg ? (rdata ^ mask) : data_reg;

endmodule

// ===== sv/framebuffer_raster_engine_unit.sv =====
// Top level of the 2D raster engine: fill, xor, glyph row and pixel read.

// The engine keeps a FB_WIDTH x FB_HEIGHT store of 24-bit pixels in one
// dual-port RAM and runs one command at a time. After reset it clears the
// whole store, one pixel a cycle, and takes the first command only once the
// last clearing write has completed; color mode writes are taken throughout.
// A fill, xor or glyph command walks its clipped pixels at one pixel per
// cycle, and an empty or fully clipped command is accepted without a walk.
// Xor reads and writes back each pixel through the registered read port and
// the write-back register. A read command issues its memory read when it is
// accepted, then waits until its result register is free; the next command
// is taken while a finished result still waits on the output channel.
// Commands are taken only once the last write of the previous command has
// completed.
module framebuffer_raster_engine_unit #(
    parameter int FB_WIDTH = 256,
    parameter int FB_HEIGHT = 256,
    parameter int GLYPH_SPAN = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [7:0]                 s_x,
    input  logic [7:0]                 s_y,
    input  logic [8:0]                 s_width,
    input  logic [8:0]                 s_height,
    input  logic [fbre_pkg::PIX_W-1:0] s_color,
    input  logic [fbre_pkg::COV_W-1:0] s_coverage,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [fbre_pkg::PIX_W-1:0] m_pixel_value
);
    import fbre_pkg::*;

`include "assert_macros.svh"

    localparam int AW = $clog2(FB_WIDTH) + $clog2(FB_HEIGHT);
    localparam int DEPTH = 1 << AW;

    logic [1:0]       color_mode_reg;
    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_pixel_value_reg, m_pixel_value_next;
    logic             out_free;
    step_t            step;
    rd_res_t          rd_res;
    logic [AW-1:0]    mem_addr, waddr;
    logic             rd_en, we, wb_busy;
    logic [PIX_W-1:0] rdata, wdata;

    // Color mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg <= MODE_888;
        end else if (cfg_we) begin
            color_mode_reg <= cfg_wdata;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    fbre_seq #(
        .FB_WIDTH   (FB_WIDTH),
        .FB_HEIGHT  (FB_HEIGHT),
        .GLYPH_SPAN (GLYPH_SPAN),
        .AW         (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_x         (s_x),
        .s_y         (s_y),
        .s_width     (s_width),
        .s_height    (s_height),
        .s_color     (s_color),
        .s_coverage  (s_coverage),
        .color_mode  (color_mode_reg),
        .wb_busy     (wb_busy),
        .out_free    (out_free),
        .step        (step),
        .mem_addr    (mem_addr),
        .rd_en       (rd_en),
        .rd_res      (rd_res)
    );

    fbre_wb #(
        .AW (AW)
    ) u_wb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .step_addr  (mem_addr),
        .color_mode (color_mode_reg),
        .rdata      (rdata),
        .busy       (wb_busy),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata)
    );

    fbre_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (mem_addr),
        .rdata (rdata)
    );

    // Result register; a read outside the store returns zero.
    always_comb begin
        m_valid_next       = m_valid_reg && !m_ready;
        m_pixel_value_next = m_pixel_value_reg;
        if (rd_res.capture) begin
            m_valid_next       = 1'b1;
            m_pixel_value_next = rd_res.hit ? rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pixel_value_reg <= m_pixel_value_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_value_reg;

    // A read never targets the pixel being written in the same cycle.
    `FBRE_ASSERT(a_no_rw_overlap, aclk, aresetn, (rd_en && we) |-> (mem_addr != waddr))
    // A read result is captured only into a free result register.
    `FBRE_ASSERT(a_capture_free, aclk, aresetn, rd_res.capture |-> out_free)
    // No transaction is taken while the write-back stage still holds a write.
    `FBRE_ASSERT(a_accept_after_wb, aclk, aresetn, (s_valid && s_ready) |-> !we)

endmodule

// ===== tb/fb_raster_checker.sv =====
// Checker for the raster engine: shadow pixel store, read prediction and result comparison.
`timescale 1ns / 1ps

module fb_raster_checker #(
    parameter int FB_WIDTH = 256,
    parameter int FB_HEIGHT = 256,
    parameter int GLYPH_SPAN = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [7:0]                 s_x,
    input  logic [7:0]                 s_y,
    input  logic [8:0]                 s_width,
    input  logic [8:0]                 s_height,
    input  logic [fbre_pkg::PIX_W-1:0] s_color,
    input  logic [fbre_pkg::COV_W-1:0] s_coverage,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [fbre_pkg::PIX_W-1:0] m_pixel_value,
    output int unsigned                fail_count,
    output int unsigned                pending_reads,
    output int unsigned                reads_checked
);
    import fbre_pkg::*;

    localparam int NUM_PIXELS = FB_WIDTH * FB_HEIGHT;
    localparam logic [7:0] COVER_MIN = 8'h80;

    // Shadow copy of the pixel store and of the color mode register.
    logic [PIX_W-1:0] shadow_fb [NUM_PIXELS];
    logic [1:0]       shadow_mode;

    // Pixel values that accepted read commands are still owed.
    logic [PIX_W-1:0] owed_pixels [$];

    // Converts an RGB color to the format that the current mode stores.
    function automatic logic [PIX_W-1:0] format_pixel(
        input logic [PIX_W-1:0] rgb,
        input logic [1:0]       mode
    );
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        red = rgb[23:16];
        green = rgb[15:8];
        blue = rgb[7:0];
        if (mode == MODE_555) begin
            return {9'd0, red[7:3], green[7:3], blue[7:3]};
        end else if (mode == MODE_565) begin
            return {8'd0, red[7:3], green[7:2], blue[7:3]};
        end
        return rgb;
    endfunction

    // Applies one accepted command to the shadow store; reads queue their pixel.
    task automatic draw_command(
        input op_t              op,
        input int               col,
        input int               row,
        input int               cols,
        input int               rows,
        input logic [PIX_W-1:0] rgb,
        input logic [COV_W-1:0] cov
    );
        int               col_end;
        int               row_end;
        int               span;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] mask;
        pix = format_pixel(rgb, shadow_mode);
        mask = (shadow_mode == MODE_555 || shadow_mode == MODE_565) ? XOR16_MASK : XOR24_MASK;
        col_end = (col + cols > FB_WIDTH) ? FB_WIDTH : col + cols;
        row_end = (row + rows > FB_HEIGHT) ? FB_HEIGHT : row + rows;
        case (op)
            OP_FILL: begin
                for (int ri = row; ri < row_end; ri++) begin
                    for (int ci = col; ci < col_end; ci++) begin
                        shadow_fb[ri * FB_WIDTH + ci] = pix;
                    end
                end
            end
            OP_XOR: begin
                for (int ri = row; ri < row_end; ri++) begin
                    for (int ci = col; ci < col_end; ci++) begin
                        shadow_fb[ri * FB_WIDTH + ci] = shadow_fb[ri * FB_WIDTH + ci] ^ mask;
                    end
                end
            end
            OP_GLYPH: begin
                // Only the first GLYPH_SPAN pixels count; covered pixels in the store are painted.
                span = (cols > GLYPH_SPAN) ? GLYPH_SPAN : cols;
                if (row < FB_HEIGHT) begin
                    for (int i = 0; i < span; i++) begin
                        if (cov[8*i +: 8] >= COVER_MIN && col + i < FB_WIDTH) begin
                            shadow_fb[row * FB_WIDTH + col + i] = pix;
                        end
                    end
                end
            end
            default: begin
                if (col < FB_WIDTH && row < FB_HEIGHT) begin
                    owed_pixels.push_back(shadow_fb[row * FB_WIDTH + col]);
                end else begin
                    owed_pixels.push_back('0);
                end
            end
        endcase
    endtask

    // Tracks configuration and command transactions and compares each pixel result.
    always @(posedge aclk) begin : watch
        logic [PIX_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PIXELS; i++) begin
                shadow_fb[i] = '0;
            end
            shadow_mode = MODE_888;
            owed_pixels.delete();
        end else begin
            if (cfg_we) begin
                shadow_mode = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                draw_command(op_t'(s_operation), int'(s_x), int'(s_y), int'(s_width),
                             int'(s_height), s_color, s_coverage);
            end
            if (m_valid && m_ready) begin
                if (owed_pixels.size() == 0) begin
                    $display("%0t: pixel result with no read outstanding: expected none, actual %06h",
                             $time, m_pixel_value);
                    fail_count <= fail_count + 1;
                end else begin
                    want = owed_pixels.pop_front();
                    reads_checked <= reads_checked + 1;
                    if (m_pixel_value !== want) begin
                        $display("%0t: pixel read mismatch: expected %06h, actual %06h",
                                 $time, want, m_pixel_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_reads <= owed_pixels.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the raster engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fbre_pkg::*;

    localparam int FB_WIDTH = 256;
    localparam int FB_HEIGHT = 256;
    localparam int GLYPH_SPAN = 8;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int BURST_READS = 6;
    localparam int PHASE_ITEMS = 18;
    localparam int NUM_PHASES = 4;
    // The longest correct silence is the clearing pass or a full-screen command;
    // the limit allows several times that.
    localparam int WATCHDOG_LIMIT = 300000;
    // The unused mode code, which the engine treats as 24-bit.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_operation = '0;
    logic [7:0]       s_x = '0;
    logic [7:0]       s_y = '0;
    logic [8:0]       s_width = '0;
    logic [8:0]       s_height = '0;
    logic [PIX_W-1:0] s_color = '0;
    logic [COV_W-1:0] s_coverage = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [PIX_W-1:0] m_pixel_value;

    int unsigned fail_count;
    int unsigned pending_reads;
    int unsigned reads_checked;

    // Stimulus bookkeeping.
    bit          steady_phase = 1'b0;
    bit          burst_active = 1'b0;
    int unsigned op_count [4];
    int          last_x = 0;
    int          last_y = 0;
    int          last_w = 0;
    int          last_h = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    framebuffer_raster_engine_unit #(
        .FB_WIDTH   (FB_WIDTH),
        .FB_HEIGHT  (FB_HEIGHT),
        .GLYPH_SPAN (GLYPH_SPAN)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_width       (s_width),
        .s_height      (s_height),
        .s_color       (s_color),
        .s_coverage    (s_coverage),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value)
    );

    fb_raster_checker #(
        .FB_WIDTH   (FB_WIDTH),
        .FB_HEIGHT  (FB_HEIGHT),
        .GLYPH_SPAN (GLYPH_SPAN)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_width       (s_width),
        .s_height      (s_height),
        .s_color       (s_color),
        .s_coverage    (s_coverage),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .fail_count    (fail_count),
        .pending_reads (pending_reads),
        .reads_checked (reads_checked)
    );

    // Result side: random stalls per transaction, plus one long hold-off during the read burst.
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge aclk) begin : result_sink
        int unsigned stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (burst_active && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (m_ready && m_valid) begin
            stall = steady_phase ? 0 : $urandom_range(0, 7);
            stall_left <= stall;
            m_ready <= (stall == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if no transaction happens for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction in %0d cycles, %0d reads still owed",
                     quiet_cycles, pending_reads);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command after a random gap and waits for its transaction.
    task automatic send_command(
        input op_t              op,
        input int               col,
        input int               row,
        input int               cols,
        input int               rows,
        input logic [PIX_W-1:0] rgb,
        input logic [COV_W-1:0] cov
    );
        int unsigned gap;
        gap = steady_phase ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_x <= col[7:0];
        s_y <= row[7:0];
        s_width <= cols[8:0];
        s_height <= rows[8:0];
        s_color <= rgb;
        s_coverage <= cov;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        op_count[op]++;
    endtask

    // Waits until every owed read has returned and the engine has settled.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_reads != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random command: mostly small rectangles, reads mostly aimed at the last painted area.
    task automatic send_random_command(input bit want_read);
        int               pick;
        int               col;
        int               row;
        int               cols;
        int               rows;
        op_t              op;
        logic [PIX_W-1:0] rgb;
        logic [COV_W-1:0] cov;
        pick = want_read ? 9 : $urandom_range(0, 9);
        col = $urandom_range(0, FB_WIDTH - 1);
        row = $urandom_range(0, FB_HEIGHT - 1);
        rgb = PIX_W'($urandom);
        cov = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin
                cols = $urandom_range(0, 256);
                rows = $urandom_range(0, 3);
            end
            1: begin
                cols = $urandom_range(0, 3);
                rows = $urandom_range(0, 256);
            end
            default: begin
                cols = $urandom_range(0, 12);
                rows = $urandom_range(0, 12);
            end
        endcase
        if (pick < 3) begin
            op = OP_FILL;
        end else if (pick < 4) begin
            op = OP_XOR;
        end else if (pick < 6) begin
            op = OP_GLYPH;
        end else begin
            op = OP_READ;
        end
        if (op == OP_READ) begin
            if (last_w > 0 && last_h > 0 && $urandom_range(0, 9) < 7) begin
                col = last_x + $urandom_range(0, last_w - 1);
                row = last_y + $urandom_range(0, last_h - 1);
                col = (col > FB_WIDTH - 1) ? FB_WIDTH - 1 : col;
                row = (row > FB_HEIGHT - 1) ? FB_HEIGHT - 1 : row;
            end
        end else begin
            last_x = col;
            last_y = row;
            last_w = (op == OP_GLYPH && cols > GLYPH_SPAN) ? GLYPH_SPAN : cols;
            last_h = (op == OP_GLYPH) ? 1 : rows;
        end
        send_command(op, col, row, cols, rows, rgb, cov);
    endtask

    // A burst of reads while the result side holds off, so the engine backs up.
    task automatic read_burst_under_hold();
        burst_active <= 1'b1;
        repeat (BURST_READS) send_random_command(1'b1);
        burst_active <= 1'b0;
    endtask

    initial begin : stimulus
        int         phase;
        logic [1:0] phase_modes [4];
        phase_modes[0] = MODE_555;
        phase_modes[1] = MODE_565;
        phase_modes[2] = MODE_SPARE;
        phase_modes[3] = MODE_888;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, 24-bit mode from reset: cleared store, full-screen fill, edge clipping,
        // empty rectangles, xor over a clipped corner and a glyph row that runs off the edge.
        send_command(OP_READ, 0, 0, 1, 1, '0, '0);
        send_command(OP_FILL, 0, 0, 256, 256, 24'ha5c3e1, '0);
        send_command(OP_READ, 255, 255, 1, 1, '0, '0);
        send_command(OP_FILL, 250, 3, 256, 2, 24'hffffff, '0);
        send_command(OP_READ, 255, 4, 1, 1, '0, '0);
        send_command(OP_FILL, 10, 252, 3, 256, 24'h123456, '0);
        send_command(OP_READ, 12, 255, 1, 1, '0, '0);
        send_command(OP_FILL, 20, 20, 0, 5, 24'h000000, '0);
        send_command(OP_XOR, 20, 20, 5, 0, '0, '0);
        send_command(OP_READ, 20, 20, 1, 1, '0, '0);
        send_command(OP_XOR, 250, 250, 256, 256, '0, '0);
        send_command(OP_READ, 252, 252, 1, 1, '0, '0);
        send_command(OP_GLYPH, 252, 100, 256, 0, 24'h00ff00, 64'hffffffff_ff807ffe);
        send_command(OP_READ, 253, 100, 1, 1, '0, '0);
        send_command(OP_READ, 254, 100, 1, 1, '0, '0);
        send_command(OP_GLYPH, 0, 101, 0, 256, 24'hffffff, '1);
        send_command(OP_READ, 0, 101, 1, 1, '0, '0);

        // 15-bit mode: xor keeps the top byte, fill converts to 555.
        wait_drained();
        set_mode(MODE_555);
        send_command(OP_XOR, 254, 254, 2, 2, '0, '0);
        send_command(OP_READ, 255, 255, 1, 1, '0, '0);
        send_command(OP_FILL, 0, 0, 4, 1, 24'hffffff, '0);
        send_command(OP_READ, 3, 0, 1, 1, '0, '0);

        // 16-bit mode: glyph paints 565 white, xor clears one of its pixels back to zero.
        wait_drained();
        set_mode(MODE_565);
        send_command(OP_GLYPH, 0, 7, 3, 0, 24'hffffff, 64'h00000000_00808080);
        send_command(OP_XOR, 1, 7, 1, 1, '0, '0);
        send_command(OP_READ, 1, 7, 1, 1, '0, '0);
        send_command(OP_READ, 2, 7, 1, 1, '0, '0);

        // Random phases, one color mode each; every phase ends on a read so that
        // its result marks the engine as idle before the next mode write.
        phase = 0;
        while (phase < NUM_PHASES) begin
            steady_phase <= (phase == 1);
            wait_drained();
            set_mode(phase_modes[phase % 4]);
            if (phase == 2) begin
                read_burst_under_hold();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_command(n == PHASE_ITEMS - 1);
            end
            phase++;
        end
        wait_drained();

        $display("Run covered %0d fill, %0d xor, %0d glyph and %0d read commands in all four modes.",
                 op_count[OP_FILL], op_count[OP_XOR], op_count[OP_GLYPH], op_count[OP_READ]);
        $display("%0d pixel reads were compared, one of them behind a %0d-cycle output hold-off.",
                 reads_checked, HOLD_CYCLES);
        if (fail_count == 0 && pending_reads == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fbre_pkg.sv
sv/fbre_ram.sv
sv/fbre_seq.sv
sv/fbre_wb.sv
sv/framebuffer_raster_engine_unit.sv
tb/fb_raster_checker.sv
tb/tb_top.sv
